### rtl/core/tfmp_pkg.sv
// Shared widths, register indexes and sequencer codes for the motion profile block.
package tfmp_pkg;

    localparam int DW   = 32;   // datapath word
    localparam int PW   = 64;   // product / radicand width
    localparam int CW   = 31;   // Q15.16 unsigned config registers
    localparam int TW   = 10;   // ticks per second
    localparam int AW   = 2;    // config index
    localparam int CNTW = 5;    // iteration counter, DW steps

    typedef enum logic [AW-1:0] {
        REG_MAX_DIST  = 2'd0,
        REG_ACCEL     = 2'd1,
        REG_MAX_SPEED = 2'd2,
        REG_TPS       = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_START = 4'b0010,
        S_WAIT  = 4'b0100,
        S_OUT   = 4'b1000
    } state_t;

    typedef enum logic [16:0] {
        OP_STEP = 17'h00001,   // div: accel / tps
        OP_DXX  = 17'h00002,   // mul: |dx|^2
        OP_DYY  = 17'h00004,   // mul: |dy|^2
        OP_DIST = 17'h00008,   // sqrt: distance
        OP_VXX  = 17'h00010,   // mul: |vx|^2
        OP_VYY  = 17'h00020,   // mul: |vy|^2
        OP_SPD  = 17'h00040,   // sqrt: current speed
        OP_BRK  = 17'h00080,   // mul: d * accel
        OP_SSQ  = 17'h00100,   // mul: speed^2
        OP_BSQ  = 17'h00200,   // sqrt: braking limit
        OP_DT   = 17'h00400,   // mul: d * tps
        OP_NX_M = 17'h00800,   // mul: x scale
        OP_NX_D = 17'h01000,   // div: x scale
        OP_NY_M = 17'h02000,
        OP_NY_D = 17'h04000,
        OP_IX   = 17'h08000,   // div: x position increment
        OP_IY   = 17'h10000
    } op_t;

endpackage

### rtl/core/tfmp_mul.sv
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
module tfmp_mul (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [tfmp_pkg::DW-1:0]  a_in,
    input  logic [tfmp_pkg::DW-1:0]  b_in,
    output logic [tfmp_pkg::PW-1:0]  prod,
    output logic                     done
);
    import tfmp_pkg::*;

    localparam logic [CNTW-1:0] CNT_LAST = CNTW'(DW - 1);

    logic [DW-1:0]   mcand_reg;
    logic [PW-1:0]   acc_reg;
    logic [PW-1:0]   acc_next;
    logic [DW:0]     upper;
    logic [CNTW-1:0] cnt_reg;
    logic            busy_reg;
    logic            done_reg;

    always_comb begin
        upper = acc_reg[0] ? ({1'b0, acc_reg[PW-1:DW]} + {1'b0, mcand_reg})
                           : {1'b0, acc_reg[PW-1:DW]};
        acc_next = {upper, acc_reg[DW-1:1]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == CNT_LAST);
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            mcand_reg <= a_in;
            acc_reg   <= {{(PW-DW){1'b0}}, b_in};
        end else if (busy_reg) begin
            acc_reg <= acc_next;
        end
    end

    assign prod = acc_reg;
    assign done = done_reg;

endmodule

### rtl/core/tfmp_div.sv
// Restoring divider, one quotient bit per cycle; quotient must fit one word.
module tfmp_div (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [tfmp_pkg::PW-1:0]  dividend,
    input  logic [tfmp_pkg::DW-1:0]  divisor,
    output logic [tfmp_pkg::DW-1:0]  quot,
    output logic                     done
);
    import tfmp_pkg::*;

    localparam logic [CNTW-1:0] CNT_LAST = CNTW'(DW - 1);

    logic [DW-1:0]   dsr_reg;
    logic [DW-1:0]   rem_reg;
    logic [DW-1:0]   rem_next;
    logic [DW-1:0]   q_reg;
    logic [DW-1:0]   q_next;
    logic [DW:0]     trial;
    logic [DW:0]     diff;
    logic            ge;
    logic [CNTW-1:0] cnt_reg;
    logic            busy_reg;
    logic            done_reg;

    always_comb begin
        trial    = {rem_reg, q_reg[DW-1]};
        ge       = trial >= {1'b0, dsr_reg};
        diff     = trial - {1'b0, dsr_reg};
        rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
        q_next   = {q_reg[DW-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == CNT_LAST);
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dsr_reg <= divisor;
            rem_reg <= dividend[PW-1:DW];
            q_reg   <= dividend[DW-1:0];
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    assign quot = q_reg;
    assign done = done_reg;

endmodule

### rtl/core/tfmp_sqrt.sv
// Digit-by-digit integer square root, two radicand bits per cycle.
module tfmp_sqrt (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic [tfmp_pkg::PW-1:0]  radicand,
    output logic [tfmp_pkg::DW-1:0]  root,
    output logic                     done
);
    import tfmp_pkg::*;

    localparam logic [CNTW-1:0] CNT_LAST = CNTW'(DW - 1);

    logic [PW-1:0]   rad_reg;
    logic [DW+1:0]   rem_reg;
    logic [DW+1:0]   rem_next;
    logic [DW-1:0]   root_reg;
    logic [DW-1:0]   root_next;
    logic [DW+3:0]   cur;
    logic [DW+3:0]   trial;
    logic [DW+3:0]   diff;
    logic            ge;
    logic [CNTW-1:0] cnt_reg;
    logic            busy_reg;
    logic            done_reg;

    always_comb begin
        cur       = {rem_reg, rad_reg[PW-1:PW-2]};
        trial     = {2'b00, root_reg, 2'b01};
        ge        = cur >= trial;
        diff      = cur - trial;
        rem_next  = ge ? diff[DW+1:0] : cur[DW+1:0];
        root_next = {root_reg[DW-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == CNT_LAST);
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rad_reg  <= {rad_reg[PW-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

### rtl/core/target_follow_motion_profile.sv
// Top level: 2D target-following trapezoidal motion profile with serial arithmetic units.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+------------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | tdata: target_x, target_y; tuser: has_target
//  m_      | out | m_tvalid/m_tready  | tdata: pos_x, pos_y, vel_x, vel_y; tuser: snapped
//  cfg_    | in  | cfg_we             | cfg_addr selects register, cfg_wdata value
//
// One beat is worked at a time; each operation runs on one of three 32-step serial units
// (multiplier, divider, square root): a start, then 32 steps, then done.
// The result sits in an output register; a new beat is taken while it waits, and the next
// result holds in S_OUT until it has gone. Reset (sync, aresetn low) clears state, loads defaults.
module target_follow_motion_profile (
    input  logic                       aclk,
    input  logic                       aresetn,
    // input beat
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [63:0]                s_tdata,   // [31:0] target_x, [63:32] target_y
    input  logic                       s_tuser,   // [0] has_target
    // result beat
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [127:0]               m_tdata,   // pos_x_out, pos_y_out, vel_x_out, vel_y_out
    output logic                       m_tuser,   // [0] snapped
    // configuration
    input  logic                       cfg_we,
    input  logic [tfmp_pkg::AW-1:0]    cfg_addr,
    input  logic [tfmp_pkg::CW-1:0]    cfg_wdata
);
    import tfmp_pkg::*;

    function automatic logic [DW-1:0] abs32(input logic [DW-1:0] v);
        abs32 = v[DW-1] ? (~v + 1'b1) : v;
    endfunction

    function automatic logic [DW-1:0] sat_add(input logic [DW-1:0] a, input logic [DW-1:0] b);
        logic [DW:0] s;
        s = {a[DW-1], a} + {b[DW-1], b};
        if (s[DW] != s[DW-1]) begin
            sat_add = s[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
        end else begin
            sat_add = s[DW-1:0];
        end
    endfunction

    // configuration
    logic [CW-1:0] md_reg, acc_reg, ms_reg;
    logic [TW-1:0] tps_reg;
    logic [TW-1:0] tps_eff;

    // sequencer
    state_t state_reg, state_next;
    op_t    op_reg, op_next;

    // beat and working registers
    logic          has_reg, has_next;
    logic [DW-1:0] tx_reg, tx_next, ty_reg, ty_next;
    logic [DW:0]   adx_reg, adx_next, ady_reg, ady_next;
    logic          sdx_reg, sdx_next, sdy_reg, sdy_next;
    logic [CW-1:0] step_reg, step_next;
    logic [PW-1:0] sum_reg, sum_next;
    logic [DW-1:0] d_reg, d_next, spd_reg, spd_next;
    logic          snap_reg, snap_next;

    // follower state
    logic [DW-1:0] fx_reg, fx_next, fy_reg, fy_next;
    logic [DW-1:0] vx_reg, vx_next, vy_reg, vy_next;

    // output register
    logic          mv_reg, mv_next;
    logic [127:0]  md_out_reg, md_out_next;
    logic          mu_reg, mu_next;

    // units
    logic          mul_start, div_start, sqrt_start;
    logic [DW-1:0] mul_a, mul_b, div_dsr;
    logic [PW-1:0] div_dvd, prod;
    logic [DW-1:0] quot, root;
    logic          mul_done, div_done, sqrt_done, unit_done;

    // combinational helpers
    logic [DW:0]   dx, dy;
    logic [DW-1:0] avx, avy;
    logic [DW-1:0] sq;
    logic [DW:0]   spd_sum;
    logic          s_acc;

    assign tps_eff = (tps_reg == '0) ? TW'(1) : tps_reg;
    assign avx     = abs32(vx_reg);
    assign avy     = abs32(vy_reg);
    assign s_tready = (state_reg == S_IDLE);
    assign s_acc   = s_tvalid && s_tready;
    assign unit_done = mul_done | div_done | sqrt_done;

    // operand selection per step
    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        div_dvd = '0;
        div_dsr = {{(DW-TW){1'b0}}, tps_eff};
        case (op_reg)
            OP_DXX: begin
                mul_a = adx_reg[DW-1:0];
                mul_b = adx_reg[DW-1:0];
            end
            OP_DYY: begin
                mul_a = ady_reg[DW-1:0];
                mul_b = ady_reg[DW-1:0];
            end
            OP_VXX: begin
                mul_a = avx;
                mul_b = avx;
            end
            OP_VYY: begin
                mul_a = avy;
                mul_b = avy;
            end
            OP_BRK: begin
                mul_a = d_reg;
                mul_b = {1'b0, acc_reg};
            end
            OP_SSQ: begin
                mul_a = spd_reg;
                mul_b = spd_reg;
            end
            OP_DT: begin
                mul_a = d_reg;
                mul_b = {{(DW-TW){1'b0}}, tps_eff};
            end
            OP_NX_M: begin
                mul_a = has_reg ? adx_reg[DW-1:0] : avx;
                mul_b = has_reg ? spd_reg : {1'b0, step_reg};
            end
            OP_NY_M: begin
                mul_a = has_reg ? ady_reg[DW-1:0] : avy;
                mul_b = has_reg ? spd_reg : {1'b0, step_reg};
            end
            OP_STEP: begin
                div_dvd = {{(PW-CW){1'b0}}, acc_reg};
            end
            OP_NX_D, OP_NY_D: begin
                div_dvd = sum_reg;
                div_dsr = has_reg ? d_reg : spd_reg;
            end
            OP_IX: begin
                div_dvd = {{(PW-DW){1'b0}}, avx};
            end
            OP_IY: begin
                div_dvd = {{(PW-DW){1'b0}}, avy};
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    always_comb begin
        mul_start  = (state_reg == S_START) &&
                     (op_reg inside {OP_DXX, OP_DYY, OP_VXX, OP_VYY, OP_BRK, OP_SSQ,
                                     OP_DT, OP_NX_M, OP_NY_M});
        div_start  = (state_reg == S_START) &&
                     (op_reg inside {OP_STEP, OP_NX_D, OP_NY_D, OP_IX, OP_IY});
        sqrt_start = (state_reg == S_START) &&
                     (op_reg inside {OP_DIST, OP_SPD, OP_BSQ});
    end

    tfmp_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a_in    (mul_a),
        .b_in    (mul_b),
        .prod    (prod),
        .done    (mul_done)
    );

    tfmp_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .quot     (quot),
        .done     (div_done)
    );

    tfmp_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (sum_reg),
        .root     (root),
        .done     (sqrt_done)
    );

    // sequencer
    always_comb begin
        dx = {s_tdata[31], s_tdata[31:0]} - {fx_reg[DW-1], fx_reg};
        dy = {s_tdata[63], s_tdata[63:32]} - {fy_reg[DW-1], fy_reg};
        spd_sum = {1'b0, root} + {2'b00, step_reg};
        sq = '0;

        state_next  = state_reg;
        op_next     = op_reg;
        has_next    = has_reg;
        tx_next     = tx_reg;
        ty_next     = ty_reg;
        adx_next    = adx_reg;
        ady_next    = ady_reg;
        sdx_next    = sdx_reg;
        sdy_next    = sdy_reg;
        step_next   = step_reg;
        sum_next    = sum_reg;
        d_next      = d_reg;
        spd_next    = spd_reg;
        snap_next   = snap_reg;
        fx_next     = fx_reg;
        fy_next     = fy_reg;
        vx_next     = vx_reg;
        vy_next     = vy_reg;
        mv_next     = mv_reg && !m_tready;
        md_out_next = md_out_reg;
        mu_next     = mu_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_acc) begin
                    has_next   = s_tuser;
                    tx_next    = s_tdata[31:0];
                    ty_next    = s_tdata[63:32];
                    sdx_next   = dx[DW];
                    sdy_next   = dy[DW];
                    adx_next   = dx[DW] ? (~dx + 1'b1) : dx;
                    ady_next   = dy[DW] ? (~dy + 1'b1) : dy;
                    snap_next  = 1'b0;
                    op_next    = OP_STEP;
                    state_next = S_START;
                end
            end
            S_START: begin
                state_next = S_WAIT;
            end
            S_WAIT: begin
                if (unit_done) begin
                    state_next = S_START;
                    case (op_reg)
                        OP_STEP: begin
                            step_next = quot[CW-1:0];
                            if (has_reg) begin
                                if (adx_reg > {2'b00, md_reg} || ady_reg > {2'b00, md_reg}) begin
                                    // far on one axis: jump onto the target
                                    vx_next    = '0;
                                    vy_next    = '0;
                                    fx_next    = tx_reg;
                                    fy_next    = ty_reg;
                                    snap_next  = 1'b1;
                                    state_next = S_OUT;
                                end else begin
                                    op_next = OP_DXX;
                                end
                            end else if (vx_reg == '0 && vy_reg == '0) begin
                                state_next = S_OUT;
                            end else begin
                                op_next = OP_VXX;
                            end
                        end
                        OP_DXX: begin
                            sum_next = prod;
                            op_next  = OP_DYY;
                        end
                        OP_DYY: begin
                            sum_next = sum_reg + prod;
                            op_next  = OP_DIST;
                        end
                        OP_DIST: begin
                            d_next = root;
                            if (root > {1'b0, md_reg}) begin
                                vx_next    = '0;
                                vy_next    = '0;
                                fx_next    = tx_reg;
                                fy_next    = ty_reg;
                                snap_next  = 1'b1;
                                state_next = S_OUT;
                            end else if (root == '0) begin
                                vx_next    = '0;
                                vy_next    = '0;
                                state_next = S_OUT;
                            end else begin
                                op_next = OP_VXX;
                            end
                        end
                        OP_VXX: begin
                            sum_next = prod;
                            op_next  = OP_VYY;
                        end
                        OP_VYY: begin
                            sum_next = sum_reg + prod;
                            op_next  = OP_SPD;
                        end
                        OP_SPD: begin
                            if (has_reg) begin
                                // accelerate, then clamp to max speed
                                spd_next = (spd_sum > {2'b00, ms_reg}) ? {1'b0, ms_reg}
                                                                        : spd_sum[DW-1:0];
                                op_next  = OP_BRK;
                            end else if ({1'b0, step_reg} < root) begin
                                spd_next = root;
                                op_next  = OP_NX_M;
                            end else begin
                                vx_next    = '0;
                                vy_next    = '0;
                                state_next = S_OUT;
                            end
                        end
                        OP_BRK: begin
                            sum_next = {prod[PW-2:0], 1'b0};
                            op_next  = OP_SSQ;
                        end
                        OP_SSQ: begin
                            op_next = (prod > sum_reg) ? OP_BSQ : OP_DT;
                        end
                        OP_BSQ: begin
                            spd_next = root;
                            op_next  = OP_DT;
                        end
                        OP_DT: begin
                            if (prod < {{(PW-DW){1'b0}}, spd_reg}) begin
                                // within one tick: snap onto the target
                                vx_next    = '0;
                                vy_next    = '0;
                                fx_next    = tx_reg;
                                fy_next    = ty_reg;
                                snap_next  = 1'b1;
                                state_next = S_OUT;
                            end else begin
                                op_next = OP_NX_M;
                            end
                        end
                        OP_NX_M: begin
                            sum_next = prod;
                            op_next  = OP_NX_D;
                        end
                        OP_NX_D: begin
                            if (has_reg) begin
                                vx_next = sdx_reg ? (~quot + 1'b1) : quot;
                            end else begin
                                sq      = vx_reg[DW-1] ? (~quot + 1'b1) : quot;
                                vx_next = vx_reg - sq;
                            end
                            op_next = OP_NY_M;
                        end
                        OP_NY_M: begin
                            sum_next = prod;
                            op_next  = OP_NY_D;
                        end
                        OP_NY_D: begin
                            if (has_reg) begin
                                vy_next = sdy_reg ? (~quot + 1'b1) : quot;
                            end else begin
                                sq      = vy_reg[DW-1] ? (~quot + 1'b1) : quot;
                                vy_next = vy_reg - sq;
                            end
                            op_next = OP_IX;
                        end
                        OP_IX: begin
                            fx_next = sat_add(fx_reg, vx_reg[DW-1] ? (~quot + 1'b1) : quot);
                            op_next = OP_IY;
                        end
                        OP_IY: begin
                            fy_next    = sat_add(fy_reg, vy_reg[DW-1] ? (~quot + 1'b1) : quot);
                            state_next = S_OUT;
                        end
                        default: begin
                            state_next = S_OUT;
                        end
                    endcase
                end
            end
            S_OUT: begin
                if (!mv_reg || m_tready) begin
                    mv_next     = 1'b1;
                    md_out_next = {vy_reg, vx_reg, fy_reg, fx_reg};
                    mu_next     = snap_reg;
                    state_next  = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control and follower state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            op_reg    <= OP_STEP;
            mv_reg    <= 1'b0;
            fx_reg    <= '0;
            fy_reg    <= '0;
            vx_reg    <= '0;
            vy_reg    <= '0;
            md_reg    <= CW'(327680);
            acc_reg   <= CW'(655360);
            ms_reg    <= CW'(655360);
            tps_reg   <= TW'(100);
        end else begin
            state_reg <= state_next;
            op_reg    <= op_next;
            mv_reg    <= mv_next;
            fx_reg    <= fx_next;
            fy_reg    <= fy_next;
            vx_reg    <= vx_next;
            vy_reg    <= vy_next;
            if (cfg_we) begin
                case (cfg_idx_t'(cfg_addr))
                    REG_MAX_DIST:  md_reg  <= cfg_wdata;
                    REG_ACCEL:     acc_reg <= cfg_wdata;
                    REG_MAX_SPEED: ms_reg  <= cfg_wdata;
                    REG_TPS:       tps_reg <= cfg_wdata[TW-1:0];
                    default:       md_reg  <= md_reg;
                endcase
            end
        end
    end

    // working payload
    always_ff @(posedge aclk) begin
        has_reg    <= has_next;
        tx_reg     <= tx_next;
        ty_reg     <= ty_next;
        adx_reg    <= adx_next;
        ady_reg    <= ady_next;
        sdx_reg    <= sdx_next;
        sdy_reg    <= sdy_next;
        step_reg   <= step_next;
        sum_reg    <= sum_next;
        d_reg      <= d_next;
        spd_reg    <= spd_next;
        snap_reg   <= snap_next;
        md_out_reg <= md_out_next;
        mu_reg     <= mu_next;
    end

    assign m_tvalid = mv_reg;
    assign m_tdata  = md_out_reg;
    assign m_tuser  = mu_reg;

endmodule

### rtl/core/tfmp_checker.sv
// Port-level checks for the motion profile top level, bound to it.
module tfmp_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [127:0] m_tdata,
    input logic         m_tuser
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat dropped or changed while stalled");

    // one beat in flight: no accept straight after an accept
    a_one_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while previous beat still in work");

    // a snapped follower is at rest
    a_snap_rest: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata[127:64] == 64'd0)
        else $error("snapped result with nonzero velocity");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind target_follow_motion_profile tfmp_checker u_tfmp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
